/* design/jas_pkg.sv */
// Shared types and constants for the joystick autocalibration scaler.
// No dependencies; imported by every module of the block but jas_fifo.
`timescale 1ns / 1ps

package jas_pkg;

  localparam int AXIS_BITS_DEF = 16;
  localparam int NUM_AXES      = 4;
  localparam int SCALE_W       = 24;
  localparam int CMD_W         = 33;
  localparam int CFG_IDX_W     = 3;
  localparam int ROUND_SHIFT   = 9;

  // Axis slots
  localparam int AX_PITCH    = 0;
  localparam int AX_ROLL     = 1;
  localparam int AX_YAW      = 2;
  localparam int AX_THROTTLE = 3;

  localparam logic [1:0]       STICK_SLIDER = 2'd1;
  localparam logic [CMD_W-1:0] OUT_LIMIT    = 33'd4294901760;

  localparam logic [SCALE_W-1:0] STICK_SCALE_RST    = 24'd839;
  localparam logic [SCALE_W-1:0] THROTTLE_SCALE_RST = 24'd50332;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEVATOR   = 3'd0,
    CFG_RUDDER     = 3'd1,
    CFG_AILERON    = 3'd2,
    CFG_THROTTLE   = 3'd3,
    CFG_STICK_TYPE = 3'd4
  } cfg_idx_e;

  // Gains are held per axis slot, not in register order.
  typedef struct packed {
    logic [NUM_AXES-1:0][SCALE_W-1:0] scale;
    logic [1:0]                       stick_type;
  } cfg_t;

  typedef struct packed {
    logic stage_busy;  // product stage holds a request
    logic out_room;    // output queue has a free slot
  } back_stat_t;

endpackage

/* design/joystick_autocal_scaler.sv */
// Top level: config registers, front end, decoupling queue, back end.
// Depends on jas_pkg, jas_fifo, jas_front and jas_back.
//
//   channel   | handshake         | payload
//   ----------+-------------------+----------------------------------------------
//   poll in   | push_i / full_o   | pitch, roll, yaw, lever, slider raw readings
//   result    | pop_i / empty_o   | elevator, aileron, rudder, throttle commands
//   config    | cfg_we_i          | cfg_idx_i, cfg_data_i (write only)
//
// One poll per cycle sustained while full_o is low; the front end updates the marks in the accept cycle.
// A result reaches the ports through the middle queue, the multiply stage and the output queue.
// Reset sets the gains to defaults, high marks to zero and low marks to all ones.
// The 2-deep middle queue and 4-deep output queue let each side stall on its own.
`timescale 1ns / 1ps

module joystick_autocal_scaler #(
  parameter int AXIS_BITS = jas_pkg::AXIS_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [AXIS_BITS-1:0]              pitch_raw_i,
  input  logic [AXIS_BITS-1:0]              roll_raw_i,
  input  logic [AXIS_BITS-1:0]              yaw_raw_i,
  input  logic [AXIS_BITS-1:0]              lever_raw_i,
  input  logic [AXIS_BITS-1:0]              slider_raw_i,
  input  logic                              pop_i,
  output logic                              empty_o,
  output logic signed [jas_pkg::CMD_W-1:0]  elevator_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0]  aileron_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0]  rudder_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0]  throttle_cmd_o,
  input  logic                              cfg_we_i,
  input  logic [jas_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [jas_pkg::SCALE_W-1:0]       cfg_data_i
);

  import jas_pkg::*;

  localparam int IW        = NUM_AXES * (AXIS_BITS + 2);
  localparam int MID_DEPTH = 2;
  localparam int OUT_DEPTH = 4;

  cfg_t             cfg_q;
  logic             accept;
  logic [IW-1:0]    front_item, mid_item;
  logic             mid_full, mid_empty, mid_pop;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;
  back_stat_t       back_stat;

  assign full_o = mid_full;
  assign accept = push_i && !mid_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale[AX_PITCH]    <= STICK_SCALE_RST;
      cfg_q.scale[AX_ROLL]     <= STICK_SCALE_RST;
      cfg_q.scale[AX_YAW]      <= STICK_SCALE_RST;
      cfg_q.scale[AX_THROTTLE] <= THROTTLE_SCALE_RST;
      cfg_q.stick_type         <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ELEVATOR:   cfg_q.scale[AX_PITCH]    <= cfg_data_i;
        CFG_RUDDER:     cfg_q.scale[AX_YAW]      <= cfg_data_i;
        CFG_AILERON:    cfg_q.scale[AX_ROLL]     <= cfg_data_i;
        CFG_THROTTLE:   cfg_q.scale[AX_THROTTLE] <= cfg_data_i;
        CFG_STICK_TYPE: cfg_q.stick_type         <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  jas_front #(
    .AXIS_BITS (AXIS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .cfg_i        (cfg_q),
    .pitch_raw_i  (pitch_raw_i),
    .roll_raw_i   (roll_raw_i),
    .yaw_raw_i    (yaw_raw_i),
    .lever_raw_i  (lever_raw_i),
    .slider_raw_i (slider_raw_i),
    .item_o       (front_item)
  );

  jas_fifo #(
    .WIDTH (IW),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (front_item),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_item),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  jas_back #(
    .AXIS_BITS (AXIS_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_valid_i   (!mid_empty),
    .item_i         (mid_item),
    .item_pop_o     (mid_pop),
    .stat_o         (back_stat),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .elevator_cmd_o (elevator_cmd_o),
    .aileron_cmd_o  (aileron_cmd_o),
    .rudder_cmd_o   (rudder_cmd_o),
    .throttle_cmd_o (throttle_cmd_o)
  );

  // A request into an idle block passes the middle queue, the product stage and the output queue to the output.
  a_idle_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && mid_empty && !back_stat.stage_busy && empty_o |-> ##3 !empty_o)
    else $error("request into idle block did not reach the output");

  // The back end only draws from the middle queue when it holds a request.
  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mid_pop && mid_empty))
    else $error("middle queue popped while empty");

  // Credit check: the product stage never lands on a full output queue.
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_stat.stage_busy |-> back_stat.out_room)
    else $error("product stage pushed into a full output queue");

  // Middle queue count tracks the front handshake.
  a_mid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !mid_pop |=> mid_count == $past(mid_count) + 1'b1)
    else $error("middle queue count out of step");

endmodule

/* design/jas_fifo.sv */
// Small register-based queue with occupancy count.
// No package dependencies; used between front and back and at the output.
`timescale 1ns / 1ps

module jas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH-1)) ? '0 : wptr_q + PW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH-1)) ? '0 : rptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

/* design/jas_front.sv */
// Front end: throttle source select, min/max mark tracking, doubled deviation
// per axis and roll sign inversion. Depends on jas_pkg.
`timescale 1ns / 1ps

module jas_front #(
  parameter int AXIS_BITS = jas_pkg::AXIS_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  jas_pkg::cfg_t         cfg_i,
  input  logic [AXIS_BITS-1:0]  pitch_raw_i,
  input  logic [AXIS_BITS-1:0]  roll_raw_i,
  input  logic [AXIS_BITS-1:0]  yaw_raw_i,
  input  logic [AXIS_BITS-1:0]  lever_raw_i,
  input  logic [AXIS_BITS-1:0]  slider_raw_i,
  output logic [jas_pkg::NUM_AXES*(AXIS_BITS+2)-1:0] item_o
);

  import jas_pkg::*;

  localparam int MW = AXIS_BITS + 1;  // doubled deviation magnitude

  logic [AXIS_BITS-1:0] hi_q [NUM_AXES];
  logic [AXIS_BITS-1:0] lo_q [NUM_AXES];
  logic [AXIS_BITS-1:0] hi_d [NUM_AXES];
  logic [AXIS_BITS-1:0] lo_d [NUM_AXES];
  logic [AXIS_BITS-1:0] src  [NUM_AXES];

  always_comb begin
    logic [MW-1:0] sum;
    logic [MW-1:0] twice;
    logic [MW-1:0] mag;
    logic          neg;
    src[AX_PITCH]    = pitch_raw_i;
    src[AX_ROLL]     = roll_raw_i;
    src[AX_YAW]      = yaw_raw_i;
    src[AX_THROTTLE] = (cfg_i.stick_type == STICK_SLIDER) ? slider_raw_i : lever_raw_i;
    item_o = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      hi_d[a] = (src[a] > hi_q[a]) ? src[a] : hi_q[a];
      lo_d[a] = (src[a] < lo_q[a]) ? src[a] : lo_q[a];
      sum     = {1'b0, hi_d[a]} + {1'b0, lo_d[a]};
      twice   = {src[a], 1'b0};
      if (twice >= sum) begin
        mag = twice - sum;
        neg = 1'b0;
      end else begin
        mag = sum - twice;
        neg = 1'b1;
      end
      if (a == AX_ROLL && cfg_i.stick_type != '0) begin
        neg = !neg;
      end
      item_o[a*(MW+1) +: MW+1] = {neg, mag};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        hi_q[a] <= '0;
        lo_q[a] <= '1;
      end
    end else if (accept_i) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        hi_q[a] <= hi_d[a];
        lo_q[a] <= lo_d[a];
      end
    end
  end

endmodule

/* design/jas_back.sv */
// Back end: gain multiply, round, clamp, sign and output queue.
// Depends on jas_pkg and jas_fifo.
`timescale 1ns / 1ps

module jas_back #(
  parameter int AXIS_BITS = jas_pkg::AXIS_BITS_DEF,
  parameter int OUT_DEPTH = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jas_pkg::cfg_t        cfg_i,
  input  logic                 item_valid_i,
  input  logic [jas_pkg::NUM_AXES*(AXIS_BITS+2)-1:0] item_i,
  output logic                 item_pop_o,
  output jas_pkg::back_stat_t  stat_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic signed [jas_pkg::CMD_W-1:0] elevator_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0] aileron_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0] rudder_cmd_o,
  output logic signed [jas_pkg::CMD_W-1:0] throttle_cmd_o
);

  import jas_pkg::*;

  localparam int MW   = AXIS_BITS + 1;
  localparam int PRW  = MW + SCALE_W;
  localparam int QW   = PRW - ROUND_SHIFT + 1;
  localparam int SW   = (QW > CMD_W) ? QW : CMD_W;
  localparam int OW   = NUM_AXES * CMD_W;
  localparam int OCW  = $clog2(OUT_DEPTH+1);

  logic [PRW-1:0]      prod_q [NUM_AXES];
  logic [NUM_AXES-1:0] neg_q;
  logic                valid_q;
  logic [OCW-1:0]      out_count;
  logic                out_full;
  logic                issue;
  logic [OW-1:0]       out_wdata, out_rdata;

  // Credit: a request enters the product stage only if it is sure of a slot.
  assign issue      = item_valid_i &&
                      ((OCW+1)'(out_count) + (OCW+1)'(valid_q) < (OCW+1)'(OUT_DEPTH));
  assign item_pop_o = issue;
  assign stat_o     = '{stage_busy: valid_q, out_room: !out_full};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        prod_q[a] <= PRW'(item_i[a*(MW+1) +: MW]) * PRW'(cfg_i.scale[a]);
        neg_q[a]  <= item_i[a*(MW+1) + MW];
      end
    end
  end

  // Round half up on the magnitude, clamp, then apply the sign.
  always_comb begin
    logic [PRW:0]       rnd;
    logic [SW-1:0]      q;
    logic [CMD_W-1:0]   mag;
    out_wdata = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      rnd = {1'b0, prod_q[a]} + (PRW+1)'(1 << (ROUND_SHIFT-1));
      q   = SW'(rnd[PRW:ROUND_SHIFT]);
      mag = (q > SW'(OUT_LIMIT)) ? OUT_LIMIT : q[CMD_W-1:0];
      out_wdata[a*CMD_W +: CMD_W] = (neg_q[a] && mag != '0) ? (CMD_W'(0) - mag) : mag;
    end
  end

  jas_fifo #(
    .WIDTH (OW),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (valid_q),
    .wdata_i (out_wdata),
    .full_o  (out_full),
    .pop_i   (pop_i),
    .rdata_o (out_rdata),
    .empty_o (empty_o),
    .count_o (out_count)
  );

  assign elevator_cmd_o = out_rdata[AX_PITCH*CMD_W    +: CMD_W];
  assign aileron_cmd_o  = out_rdata[AX_ROLL*CMD_W     +: CMD_W];
  assign rudder_cmd_o   = out_rdata[AX_YAW*CMD_W      +: CMD_W];
  assign throttle_cmd_o = out_rdata[AX_THROTTLE*CMD_W +: CMD_W];

endmodule

/* sim/joystick_autocal_scaler_tb.sv */
// Self-checking testbench for joystick_autocal_scaler: random and directed polls
// against an in-bench min/max tracker and gain model. Depends on jas_pkg and the RTL.
`timescale 1ns / 1ps

module joystick_autocal_scaler_tb;
  import jas_pkg::*;

  localparam int AW  = AXIS_BITS_DEF;
  localparam int MID = 1 << (AW - 1);

  // stick_type codes besides the slider one
  localparam logic [1:0] STICK_PLAIN = 2'd0;
  localparam logic [1:0] STICK_INV_A = 2'd2;
  localparam logic [1:0] STICK_INV_B = 2'd3;

  localparam logic [SCALE_W-1:0] GAIN_MAX = '1;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    logic [AW-1:0] pitch;
    logic [AW-1:0] roll;
    logic [AW-1:0] yaw;
    logic [AW-1:0] lever;
    logic [AW-1:0] slider;
  } poll_t;

  typedef struct {
    logic [CMD_W-1:0] elevator;
    logic [CMD_W-1:0] aileron;
    logic [CMD_W-1:0] rudder;
    logic [CMD_W-1:0] throttle;
  } cmd_t;

  class cmd_scoreboard;
    logic [AW-1:0]      high_mark [NUM_AXES];
    logic [AW-1:0]      low_mark  [NUM_AXES];
    logic [SCALE_W-1:0] gain      [NUM_AXES];  // by axis slot
    logic [1:0]         stick;
    cmd_t               cmds_due [$];
    int                 mismatches;

    function new();
      for (int i = 0; i < NUM_AXES; i++) begin
        high_mark[i] = '0;
        low_mark[i]  = '1;
        gain[i]      = (i == AX_THROTTLE) ? THROTTLE_SCALE_RST : STICK_SCALE_RST;
      end
      stick      = STICK_PLAIN;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
      case (idx)
        CFG_ELEVATOR:   gain[AX_PITCH]    = data;
        CFG_RUDDER:     gain[AX_YAW]      = data;
        CFG_AILERON:    gain[AX_ROLL]     = data;
        CFG_THROTTLE:   gain[AX_THROTTLE] = data;
        CFG_STICK_TYPE: stick             = data[1:0];
        default: ;
      endcase
    endfunction

    // Update the marks, then scale the doubled deviation from neutral.
    // Rounding is on the magnitude so a negated axis stays symmetric.
    function logic [CMD_W-1:0] deflection(int ax, logic [AW-1:0] s, bit invert);
      logic [AW:0]           twice;
      logic [AW:0]           sum;
      logic [AW:0]           mag;
      logic [AW+SCALE_W+1:0] q;
      bit                    neg;
      if (s > high_mark[ax]) high_mark[ax] = s;
      if (s < low_mark[ax]) low_mark[ax] = s;
      twice = {s, 1'b0};
      sum   = high_mark[ax] + low_mark[ax];
      if (twice >= sum) begin
        mag = twice - sum;
        neg = 1'b0;
      end else begin
        mag = sum - twice;
        neg = 1'b1;
      end
      q = (mag * gain[ax] + (1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
      if (q > OUT_LIMIT) q = OUT_LIMIT;
      if (invert) neg = !neg;
      if (q == 0) neg = 1'b0;
      return neg ? -q[CMD_W-1:0] : q[CMD_W-1:0];
    endfunction

    function void take_poll(poll_t p);
      cmd_t c;
      c.elevator = deflection(AX_PITCH, p.pitch, 1'b0);
      c.aileron  = deflection(AX_ROLL, p.roll, stick != STICK_PLAIN);
      c.rudder   = deflection(AX_YAW, p.yaw, 1'b0);
      c.throttle = deflection(AX_THROTTLE, (stick == STICK_SLIDER) ? p.slider : p.lever,
                              1'b0);
      cmds_due.push_back(c);
    endfunction

    function void compare(string field, logic [CMD_W-1:0] want, logic [CMD_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field,
                 $signed(want), $signed(got));
        mismatches++;
      end
    endfunction

    function void match_cmds(logic [CMD_W-1:0] e, logic [CMD_W-1:0] a,
                             logic [CMD_W-1:0] r, logic [CMD_W-1:0] t);
      cmd_t want;
      if (cmds_due.size() == 0) begin
        $display("%0t: result popped with no request pending", $time);
        mismatches++;
        return;
      end
      want = cmds_due.pop_front();
      compare("elevator", want.elevator, e);
      compare("aileron", want.aileron, a);
      compare("rudder", want.rudder, r);
      compare("throttle", want.throttle, t);
    endfunction
  endclass

  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       push_i       = 1'b0;
  logic                       full_o;
  logic [AW-1:0]              pitch_raw_i  = '0;
  logic [AW-1:0]              roll_raw_i   = '0;
  logic [AW-1:0]              yaw_raw_i    = '0;
  logic [AW-1:0]              lever_raw_i  = '0;
  logic [AW-1:0]              slider_raw_i = '0;
  logic                       pop_i        = 1'b0;
  logic                       empty_o;
  logic signed [CMD_W-1:0]    elevator_cmd_o;
  logic signed [CMD_W-1:0]    aileron_cmd_o;
  logic signed [CMD_W-1:0]    rudder_cmd_o;
  logic signed [CMD_W-1:0]    throttle_cmd_o;
  logic                       cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i    = '0;
  logic [SCALE_W-1:0]         cfg_data_i   = '0;

  int poll_gap_pct  = 0;
  int pop_stall_pct = 0;

  cmd_scoreboard sb = new;

  joystick_autocal_scaler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .pitch_raw_i    (pitch_raw_i),
    .roll_raw_i     (roll_raw_i),
    .yaw_raw_i      (yaw_raw_i),
    .lever_raw_i    (lever_raw_i),
    .slider_raw_i   (slider_raw_i),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .elevator_cmd_o (elevator_cmd_o),
    .aileron_cmd_o  (aileron_cmd_o),
    .rudder_cmd_o   (rudder_cmd_o),
    .throttle_cmd_o (throttle_cmd_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    pop_i <= ($urandom_range(0, 99) >= pop_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) begin
      sb.match_cmds(elevator_cmd_o, aileron_cmd_o, rudder_cmd_o, throttle_cmd_o);
    end
  end

  function automatic void set_idle(idle_e mode);
    case (mode)
      IDLE_NONE: begin poll_gap_pct = 0;  pop_stall_pct = 0;  end
      IDLE_SEND: begin poll_gap_pct = 61; pop_stall_pct = 0;  end
      IDLE_RECV: begin poll_gap_pct = 0;  pop_stall_pct = 61; end
      default:   begin poll_gap_pct = 19; pop_stall_pct = 19; end
    endcase
  endfunction

  function automatic poll_t mk_poll(logic [AW-1:0] p, logic [AW-1:0] r, logic [AW-1:0] y,
                                    logic [AW-1:0] l, logic [AW-1:0] s);
    poll_t v;
    v.pitch  = p;
    v.roll   = r;
    v.yaw    = y;
    v.lever  = l;
    v.slider = s;
    return v;
  endfunction

  // win > 0: reading within +/- win of mid scale, so the marks widen slowly.
  // win == 0: full range with the rails weighted up.
  function automatic logic [AW-1:0] pick_reading(int win);
    int r;
    if (win > 0) return AW'(MID - win + $urandom_range(0, 2 * win));
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return AW'($urandom());
  endfunction

  task automatic send_poll(poll_t p);
    while ($urandom_range(0, 99) < poll_gap_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i       <= 1'b1;
    pitch_raw_i  <= p.pitch;
    roll_raw_i   <= p.roll;
    yaw_raw_i    <= p.yaw;
    lever_raw_i  <= p.lever;
    slider_raw_i <= p.slider;
    do @(posedge clk_i); while (full_o);
    sb.take_poll(p);
  endtask

  task automatic run_polls(int count, int win_lo, int win_hi);
    int win;
    for (int i = 0; i < count; i++) begin
      win = win_lo + (win_hi - win_lo) * i / count;
      send_poll(mk_poll(pick_reading(win), pick_reading(win), pick_reading(win),
                        pick_reading(win), pick_reading(win)));
    end
  endtask

  task automatic drain();
    push_i <= 1'b0;
    while (sb.cmds_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic load_gains(logic [SCALE_W-1:0] elev, logic [SCALE_W-1:0] rud,
                            logic [SCALE_W-1:0] ail, logic [SCALE_W-1:0] thr,
                            logic [1:0] stick);
    cfg_write(CFG_ELEVATOR, elev);
    cfg_write(CFG_RUDDER, rud);
    cfg_write(CFG_AILERON, ail);
    cfg_write(CFG_THROTTLE, thr);
    cfg_write(CFG_STICK_TYPE, {{(SCALE_W - 2){1'b0}}, stick});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    set_idle(IDLE_NONE);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // writes to unmapped indexes must leave the reset gains alone
    for (int k = CFG_STICK_TYPE + 1; k < 2 ** CFG_IDX_W; k++) begin
      cfg_write(CFG_IDX_W'(k), SCALE_W'($urandom()));
    end
    cfg_we_i <= 1'b0;

    // first poll sets both marks, so every axis reads zero
    send_poll(mk_poll(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h1234));
    send_poll(mk_poll(16'h8001, 16'h7fff, 16'h8000, 16'h8002, 16'h0000));
    send_poll(mk_poll(16'h7ffe, 16'h8003, 16'h8001, 16'h7fff, 16'hffff));
    send_poll(mk_poll(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    drain();

    // slowly widening marks, slider first, then the lever takes over throttle
    load_gains(SCALE_W'($urandom()), SCALE_W'($urandom()), SCALE_W'($urandom()),
               SCALE_W'($urandom()), STICK_SLIDER);
    run_polls(200, 1, 12000);
    drain();
    set_idle(IDLE_RECV);
    load_gains(SCALE_W'($urandom()), SCALE_W'($urandom()), SCALE_W'($urandom()),
               SCALE_W'($urandom()), STICK_PLAIN);
    run_polls(200, 12000, 32767);
    drain();

    // rails and bit patterns at full gain, roll inverted
    set_idle(IDLE_NONE);
    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, STICK_INV_A);
    send_poll(mk_poll(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_poll(mk_poll(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_poll(mk_poll(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa));
    send_poll(mk_poll(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555));
    send_poll(mk_poll(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_poll(mk_poll(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
    send_poll(mk_poll(16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000));
    send_poll(mk_poll(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff));
    drain();

    set_idle(IDLE_SEND);
    load_gains('0, GAIN_MAX, SCALE_W'($urandom()), 24'd1, STICK_SLIDER);
    send_poll(mk_poll(16'h1234, 16'h4321, 16'h0001, 16'hffff, 16'h0000));
    send_poll(mk_poll(16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'hffff));
    run_polls(250, 0, 0);
    drain();

    set_idle(IDLE_RECV);
    load_gains(SCALE_W'($urandom()), SCALE_W'($urandom()), SCALE_W'($urandom()),
               SCALE_W'($urandom()), STICK_INV_B);
    run_polls(300, 0, 0);
    drain();

    set_idle(IDLE_BOTH);
    load_gains(STICK_SCALE_RST, STICK_SCALE_RST, STICK_SCALE_RST, THROTTLE_SCALE_RST,
               STICK_PLAIN);
    run_polls(300, 0, 0);
    drain();

    set_idle(IDLE_SEND);
    load_gains(SCALE_W'($urandom()), SCALE_W'($urandom()), SCALE_W'($urandom()),
               SCALE_W'($urandom()), STICK_INV_A);
    run_polls(250, 0, 0);
    drain();

    // catch any stray result after the last request
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("** joystick_autocal_scaler: PASSED **");
    end else begin
      $display("** joystick_autocal_scaler: FAILED **");
    end
    $finish;
  end

  initial begin
    #3_600_000;
    $display("timeout");
    $display("** joystick_autocal_scaler: FAILED **");
    $finish;
  end

endmodule
